>>> design/wyrng_pkg.sv
// Package for the wyhash16 unbiased range generator.
// Holds hash constants, controller states and the command/status structs.
// No dependencies.
package wyrng_pkg;

   localparam logic [15:0] WEYL_STEP = 16'hfc15;
   localparam logic [9:0]  HASH_KEY  = 10'h2ab;
   localparam int          DIV_STEPS = 16;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HASH,
      ST_MUL,
      ST_CHECK,
      ST_DIV,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic load_req;
      logic hash;
      logic mul;
      logic div_init;
      logic div_step;
      logic redraw;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic below_s;
      logic below_t;
      logic div_last;
      logic tries_full;
   } sts_type;

endpackage

>>> design/wyhash16_unbiased_range_rng.sv
// Unbiased bounded random generator: Weyl counter, wyhash16 mix, multiply and reject.
// With no threshold a draw goes through ST_HASH, ST_MUL, ST_CHECK and ST_OUT; a threshold
// adds the ST_DIV steps (one-bit-per-cycle remainder divider), and each rejected draw
// repeats ST_HASH, ST_MUL and ST_CHECK. The next item is accepted once the result
// is in the output register, and a stalled result holds the controller until taken.
// Synchronous reset clears the controller, the output valid and the counter to zero.
module wyhash16_unbiased_range_rng import wyrng_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_range_bound,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_random_value,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_seed_value
);

   cmd_type cmd;
   sts_type sts;

   wyrng_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   wyrng_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_range_bound  (req_range_bound),
      .csr_write_enable (csr_write_enable),
      .csr_seed_value   (csr_seed_value),
      .rsp_random_value (rsp_random_value)
   );

endmodule

>>> design/wyrng_dp.sv
// Datapath: Weyl counter, hash and range multipliers, threshold divider,
// retry counter and result register. Depends on wyrng_pkg.
module wyrng_dp import wyrng_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output sts_type     sts,
   input  logic [15:0] req_range_bound,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_seed_value,
   output logic [15:0] rsp_random_value
);

   logic [15:0] counter_ff, counter_in;
   logic [15:0] bound_ff, bound_in;
   logic [15:0] hash_ff, hash_in;
   logic [31:0] prod_ff, prod_in;
   logic [15:0] rem_ff, rem_in;
   logic [15:0] dvd_ff, dvd_in;
   logic [3:0]  div_cnt_ff, div_cnt_in;
   logic [16:0] tries_ff, tries_in;
   logic [15:0] result_ff, result_in;

   logic [25:0] mix_prod;
   logic [16:0] rem_shift;
   logic [16:0] rem_diff;

   always_comb begin
      mix_prod  = counter_ff * HASH_KEY;
      rem_shift = {rem_ff, dvd_ff[15]};
      rem_diff  = rem_shift - {1'b0, bound_ff};

      counter_in = counter_ff;
      if (csr_write_enable) begin
         counter_in = csr_seed_value;
      end else if (cmd.load_req || cmd.redraw) begin
         counter_in = counter_ff + WEYL_STEP;
      end

      bound_in = cmd.load_req ? req_range_bound : bound_ff;
      hash_in  = cmd.hash ? (mix_prod[15:0] ^ {6'd0, mix_prod[25:16]}) : hash_ff;
      prod_in  = cmd.mul ? (hash_ff * bound_ff) : prod_ff;

      rem_in     = rem_ff;
      dvd_in     = dvd_ff;
      div_cnt_in = div_cnt_ff;
      if (cmd.div_init) begin
         rem_in     = 16'd0;
         dvd_in     = 16'd0 - bound_ff;
         div_cnt_in = 4'd0;
      end else if (cmd.div_step) begin
         rem_in     = rem_diff[16] ? rem_shift[15:0] : rem_diff[15:0];
         dvd_in     = {dvd_ff[14:0], 1'b0};
         div_cnt_in = div_cnt_ff + 4'd1;
      end

      tries_in = tries_ff;
      if (cmd.load_req) begin
         tries_in = 17'd0;
      end else if (cmd.redraw) begin
         tries_in = tries_ff + 17'd1;
      end

      result_in = cmd.load_out ? prod_ff[31:16] : result_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff <= 16'd0;
      end else begin
         counter_ff <= counter_in;
      end
   end

   always_ff @(posedge clock) begin
      bound_ff   <= bound_in;
      hash_ff    <= hash_in;
      prod_ff    <= prod_in;
      rem_ff     <= rem_in;
      dvd_ff     <= dvd_in;
      div_cnt_ff <= div_cnt_in;
      tries_ff   <= tries_in;
      result_ff  <= result_in;
   end

   always_comb begin
      sts.below_s    = prod_ff[15:0] < bound_ff;
      sts.below_t    = prod_ff[15:0] < rem_ff;
      sts.div_last   = div_cnt_ff == 4'(DIV_STEPS - 1);
      sts.tries_full = tries_ff[16];
   end

   assign rsp_random_value = result_ff;

endmodule

>>> design/wyrng_ctrl.sv
// Controller: sequences draw, hash, multiply, threshold division and
// rejection retries, and owns both handshakes. Depends on wyrng_pkg.
module wyrng_ctrl import wyrng_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;
   logic      thr_ff, thr_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         thr_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         thr_ff       <= thr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      thr_in       = thr_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      req_stall    = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               thr_in       = 1'b0;
               state_in     = ST_HASH;
            end
         end
         ST_HASH: begin
            cmd.hash = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (!thr_ff) begin
               if (sts.below_s) begin
                  cmd.div_init = 1'b1;
                  state_in     = ST_DIV;
               end else begin
                  state_in = ST_OUT;
               end
            end else if (sts.below_t && !sts.tries_full) begin
               cmd.redraw = 1'b1;
               state_in   = ST_HASH;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               thr_in   = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> bench/tb.sv
// Self-checking bench for wyhash16_unbiased_range_rng: bounded draws under random flow control.
// Holds its own Weyl-counter/hash/reject predictor and an in-order check of every item.
// Depends only on the RTL top level and its package.
module tb;

   localparam logic [15:0] WEYL_INC    = 16'hfc15;
   localparam logic [31:0] MIX_KEY     = 32'h0000_02ab;
   localparam int unsigned RETRY_LIMIT = 65536;
   localparam int unsigned CYCLE_LIMIT = 1_500_000;
   localparam int unsigned HOLD_CYCLES = 300;
   localparam int unsigned IDLE_PCT    = 22;

   class range_draw_board;
      logic [15:0] weyl_count;
      logic [15:0] expected_values[$];
      int unsigned mismatch_count;

      function new();
         weyl_count = '0;
         mismatch_count = 0;
      endfunction

      function void reseed(logic [15:0] seed);
         weyl_count = seed;
      endfunction

      function logic [15:0] next_hash();
         logic [31:0] prod;
         weyl_count = weyl_count + WEYL_INC;
         prod = 32'(weyl_count) * MIX_KEY;
         return prod[31:16] ^ prod[15:0];
      endfunction

      function logic [15:0] predict_draw(logic [15:0] bound);
         logic [31:0] prod;
         logic [31:0] thresh;
         int unsigned tries;
         prod = 32'(next_hash()) * 32'(bound);
         if (prod[15:0] < bound) begin
            thresh = ((32'h0001_0000 - 32'(bound)) & 32'h0000_ffff) % 32'(bound);
            tries = 0;
            while (32'(prod[15:0]) < thresh && tries < RETRY_LIMIT) begin
               prod = 32'(next_hash()) * 32'(bound);
               tries++;
            end
         end
         return prod[31:16];
      endfunction

      function void note_request(logic [15:0] bound);
         expected_values.push_back(predict_draw(bound));
      endfunction

      task report(string msg);
         if (mismatch_count < 100)
            $display("ERROR: %s", msg);
         mismatch_count++;
      endtask

      task check_result(logic [15:0] value);
         logic [15:0] want;
         if (expected_values.size() == 0) begin
            report($sformatf("unexpected item random_value=%0d", value));
         end else begin
            want = expected_values.pop_front();
            if (value !== want)
               report($sformatf("random_value=%0d, predicted %0d", value, want));
         end
      endtask

      task close_out();
         if (expected_values.size() != 0)
            report($sformatf("%0d items never returned", expected_values.size()));
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [15:0] req_range_bound;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [15:0] rsp_random_value;
   logic        csr_write_enable;
   logic [15:0] csr_seed_value;

   logic        no_idle;
   logic        hold_armed;
   logic        hold_done;
   int unsigned hold_left;
   int unsigned cycle_count;

   range_draw_board board;

   wyhash16_unbiased_range_rng i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_range_bound  (req_range_bound),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_random_value (rsp_random_value),
      .csr_write_enable (csr_write_enable),
      .csr_seed_value   (csr_seed_value)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TEST FAILED");
      $finish;
   end

   // receiver: check accepted items, then pick next stall
   initial begin
      rsp_stall <= 1'b0;
      hold_done = 1'b0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall)
            board.check_result(rsp_random_value);
         if (hold_armed && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !no_idle && ($urandom_range(0, 99) < IDLE_PCT);
         end
      end
   end

   task automatic send_item(input logic [15:0] bound);
      int unsigned gap;
      gap = 0;
      if (!no_idle)
         while ($urandom_range(0, 99) < IDLE_PCT)
            gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_range_bound <= bound;
      do @(posedge clock); while (req_stall);
      board.note_request(bound);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.expected_values.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_seed(input logic [15:0] seed);
      csr_seed_value <= seed;
      csr_write_enable <= 1'b1;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      board.reseed(seed);
   endtask

   function automatic logic [15:0] pick_bound();
      int unsigned sel;
      sel = $urandom_range(0, 99);
      if (sel < 40)
         return 16'($urandom_range(1, 65535));
      if (sel < 60)
         return 16'($urandom_range(1, 64));
      if (sel < 80)
         return 16'($urandom_range(32769, 65535));
      if (sel < 98)
         return 16'($urandom_range(16385, 32768));
      return 16'h0000;
   endfunction

   task automatic run_random(input int count, input int hold_at, input int pause_at);
      for (int k = 0; k < count; k++) begin
         if (k == hold_at)
            hold_armed <= 1'b1;
         if (k == pause_at)
            wait_drained();
         send_item(pick_bound());
      end
      wait_drained();
   endtask

   initial begin
      logic [15:0] directed[$];
      directed = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd65535, 16'd65534, 16'd32768,
                   16'd32769, 16'd32767, 16'h5555, 16'haaaa, 16'd49153, 16'd7,
                   16'd100, 16'd65533, 16'd40000, 16'd0, 16'd1, 16'd65535, 16'd32770};
      board = new();
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_range_bound <= '0;
      csr_write_enable <= 1'b0;
      csr_seed_value <= '0;
      no_idle <= 1'b0;
      hold_armed <= 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // counter starts from its reset value
      foreach (directed[i])
         send_item(directed[i]);
      wait_drained();

      write_seed(16'hffff);
      run_random(450, -1, -1);

      write_seed(16'($urandom));
      no_idle <= 1'b1;
      run_random(400, -1, -1);
      no_idle <= 1'b0;

      write_seed(16'h0001);
      run_random(500, 100, 300);

      write_seed(16'h0000);
      run_random(300, -1, -1);

      write_seed(16'h8000);
      run_random(250, -1, 120);

      repeat (40) @(posedge clock);
      board.close_out();
      if (board.mismatch_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

>>> files.f
design/wyrng_pkg.sv
design/wyrng_dp.sv
design/wyrng_ctrl.sv
design/wyhash16_unbiased_range_rng.sv
bench/tb.sv
